// ----- src/register_usage_table_macros.svh -----
// Assertion macros of the register usage table checker.
`ifndef REGISTER_USAGE_TABLE_MACROS_SVH
`define REGISTER_USAGE_TABLE_MACROS_SVH

// Clocked property, switched off while the reset is held.
`define RUT_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define RUT_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rut_pkg.sv -----
// Package of the register usage table: codes, entry type, defaults and a mode helper.
`default_nettype none

package rut_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  mode;
  } entry_t;

  // Take the unused mode code as modify.
  function automatic logic [1:0] norm_mode(input logic [1:0] m);
    norm_mode = (m > MODE_MODIFY) ? MODE_MODIFY : m;
  endfunction

endpackage

`default_nettype wire

// ----- src/register_usage_table.sv -----
// Register usage table: associative key/mode store with a sequential key scan.
//
//  channel   handshake               payload
//  command   start, busy (out)       kind, reg_key, access_mode, read_index
//  result    done (one-cycle strobe) entry_index, entry_key, entry_mode,
//                                    was_inserted, table_full, entry_valid,
//                                    entry_count
//
// Clear and unknown kinds and a read beyond the count finish straight from
// idle; a read inside the count waits for one memory read. An add scans the
// stored keys from position 0 and ends at the first match or after the last
// entry: the single read port of the entry memory delivers one key per
// cycle, so a miss on a full table reads all DEPTH keys. An add to an empty
// table writes at once, with no scan.
// Reset (rst, synchronous) empties the table by zeroing the count; the entry
// memory itself is not cleared. The result receiver cannot stall: each
// result is shown for exactly one cycle, and the next command may be taken
// in that same cycle.
`default_nettype none

module register_usage_table #(
  parameter int DEPTH = rut_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] reg_key,
  input  wire logic [1:0]  access_mode,
  input  wire logic [3:0]  read_index,
  output logic             done,
  output logic [3:0]       entry_index,
  output logic [31:0]      entry_key,
  output logic [1:0]       entry_mode,
  output logic             was_inserted,
  output logic             table_full,
  output logic             entry_valid,
  output logic [4:0]       entry_count
);

  // Index and count widths; compares against read_index use the wider of two.
  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [IW-1:0] scan_idx, scan_idx_next;
  logic [31:0]   key_q;
  logic [1:0]    mode_q;

  // Entry memory: one write and one registered read per cycle.
  rut_pkg::entry_t mem [DEPTH];
  rut_pkg::entry_t rd_data;
  logic [IW-1:0]   rd_addr;
  logic            we;
  logic [IW-1:0]   wa;
  rut_pkg::entry_t wd;

  // Result to load into the output register.
  logic          emit;
  logic [IW-1:0] r_idx;
  logic [31:0]   r_key;
  logic [1:0]    r_mode;
  logic          r_ins, r_full, r_valid, r_idx_zero;

  logic [1:0]    in_mode;
  logic          last_entry;

  assign in_mode    = rut_pkg::norm_mode(access_mode);
  assign last_entry = (CW'(scan_idx) + CW'(1)) >= count;
  assign busy       = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = '{key: key_q, mode: mode_q};
    emit          = 1'b0;
    r_idx         = '0;
    r_idx_zero    = 1'b0;
    r_key         = '0;
    r_mode        = '0;
    r_ins         = 1'b0;
    r_full        = 1'b0;
    r_valid       = 1'b0;

    case (state)
      ST_IDLE: begin
        // Issue the read for the command in the same cycle it is taken.
        rd_addr = (kind == rut_pkg::KIND_READ) ? IW'(read_index) : '0;
        if (start) begin
          case (kind)
            rut_pkg::KIND_ADD: begin
              if (count == '0) begin
                // Empty table: append straight away.
                we         = 1'b1;
                wa         = '0;
                wd         = '{key: reg_key, mode: in_mode};
                count_next = CW'(1);
                emit       = 1'b1;
                r_key      = reg_key;
                r_mode     = in_mode;
                r_ins      = 1'b1;
              end else begin
                scan_idx_next = '0;
                state_next    = ST_SCAN;
              end
            end
            rut_pkg::KIND_CLEAR: begin
              count_next = '0;
              emit       = 1'b1;
              r_idx_zero = 1'b1;
            end
            rut_pkg::KIND_READ: begin
              if (CMPW'(read_index) < CMPW'(count)) begin
                scan_idx_next = IW'(read_index);
                state_next    = ST_READ;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        rd_addr = scan_idx + IW'(1);
        if (rd_data.key == key_q) begin
          // Hit: merge a differing mode to modify.
          emit       = 1'b1;
          r_idx      = scan_idx;
          r_key      = rd_data.key;
          r_mode     = rd_data.mode;
          state_next = ST_IDLE;
          if (rd_data.mode != mode_q) begin
            we     = 1'b1;
            wa     = scan_idx;
            wd     = '{key: rd_data.key, mode: rut_pkg::MODE_MODIFY};
            r_mode = rut_pkg::MODE_MODIFY;
          end
        end else if (!last_entry) begin
          scan_idx_next = scan_idx + IW'(1);
        end else begin
          emit       = 1'b1;
          r_key      = key_q;
          r_mode     = mode_q;
          state_next = ST_IDLE;
          if (count == CW'(DEPTH)) begin
            r_full = 1'b1;
          end else begin
            we         = 1'b1;
            wa         = IW'(count);
            count_next = count + CW'(1);
            r_idx      = IW'(count);
            r_ins      = 1'b1;
          end
        end
      end

      ST_READ: begin
        emit       = 1'b1;
        r_idx      = scan_idx;
        r_key      = rd_data.key;
        r_mode     = rd_data.mode;
        r_valid    = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  // Hold the command fields and scan position; load the result on emit.
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    if (start && !busy) begin
      key_q  <= reg_key;
      mode_q <= in_mode;
    end
    if (emit) begin
      entry_index  <= r_idx_zero ? 4'd0 : 4'(r_idx);
      entry_key    <= r_key;
      entry_mode   <= r_mode;
      was_inserted <= r_ins;
      table_full   <= r_full;
      entry_valid  <= r_valid;
      entry_count  <= 5'(count_next);
    end
  end

endmodule

`default_nettype wire

// ----- src/rut_checker.sv -----
// Port-level checker of the register usage table, bound into that module.
`default_nettype none
`include "register_usage_table_macros.svh"

module rut_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        was_inserted,
  input wire logic        table_full,
  input wire logic        entry_valid,
  input wire logic [4:0]  entry_count
);

  // A taken command either finishes at once or holds the block busy.
  `RUT_ASSERT_RST(a_take_progress, clk, rst, (start && !busy) |=> (done || busy), "command lost")

  // A busy spell ends with a result.
  `RUT_ASSERT_RST(a_busy_end, clk, rst, (!$past(rst) && $fell(busy)) |-> done, "no result at end")

  // An inserted entry leaves a non-empty table, and flags are exclusive.
  `RUT_ASSERT_RST(a_insert_flags, clk, rst, (done && was_inserted) |-> (entry_count != 5'd0 && !table_full && !entry_valid), "bad insert flags")

  // Reset leaves the block idle with no result.
  `RUT_ASSERT(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind register_usage_table rut_checker u_rut_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .was_inserted (was_inserted),
  .table_full   (table_full),
  .entry_valid  (entry_valid),
  .entry_count  (entry_count)
);

`default_nettype wire
